### design/lgpr_pkg.sv
// Shared constants, the 5x7 font ROM and the byte slot codes of the glyph page renderer.
// No dependencies; imported by the renderer top level.
package lgpr_pkg;

   // Default geometry of the panel, handed to the top level as parameter defaults.
   localparam int DEF_PAGE_COUNT   = 8;
   localparam int DEF_COLUMN_COUNT = 128;

   // Fixed font geometry.
   localparam int GLYPH_COLUMNS = 5;
   localparam int GLYPH_TOTAL   = 95;
   localparam logic [6:0] FIRST_CODE = 7'd32;

   // Display controller command codes.
   localparam logic [7:0] CMD_PAGE_SELECT = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH    = 8'h10;
   localparam logic [7:0] NIBBLE_MASK     = 8'h0F;

   // Position of a word inside the four-word group sent for one cell.
   typedef enum logic [1:0] {
      SLOT_PAGE,
      SLOT_COL_HIGH,
      SLOT_COL_LOW,
      SLOT_DATA
   } slot_type;

   // One row per glyph; column 0 sits in the lowest byte, bit 0 of a byte is the top pixel.
   localparam logic [39:0] FONT_ROM [0:GLYPH_TOTAL-1] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h00126B2400, 40'h6364081363, 40'h5036494936, 40'h0000070000,
      40'h0000413E00, 40'h003E410000, 40'h0005020500, 40'h00081C0800,
      40'h0000608000, 40'h0008080800, 40'h0000400000, 40'h0304081060,
      40'h3E4549513E, 40'h007F020408, 40'h4649516142, 40'h3649494122,
      40'h107F121418, 40'h3945454527, 40'h324949493E, 40'h0305091161,
      40'h3649494936, 40'h3E49494926, 40'h0000140000, 40'h0000748000,
      40'h0022140800, 40'h0014141400, 40'h0008142200, 40'h0609510102,
      40'h7C08705020, 40'h7C1211127C, 40'h364949497F, 40'h224141413E,
      40'h3E4141417F, 40'h414949497F, 40'h010909097F, 40'h794949413E,
      40'h7F0808087F, 40'h41417F4141, 40'h7F81818141, 40'h412214087F,
      40'h404040407F, 40'h7F0204027F, 40'h7F3008067F, 40'h3E4141413E,
      40'h0E1111117F, 40'h7E6151413E, 40'h4E3111117F, 40'h3249494926,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F403F403F,
      40'h4136083641, 40'h0304780403, 40'h4345495161, 40'h0000417F00,
      40'h6010080403, 40'h00007F4100, 40'h0402010204, 40'h8080808080,
      40'h0402010000, 40'h0078545424, 40'h003048487F, 40'h2844444438,
      40'h7F44444438, 40'h0854545438, 40'h0009097E00, 40'h0078A4A498,
      40'h780404047F, 40'h00007D0000, 40'h00007A8040, 40'h004428107F,
      40'h40407F4140, 40'h7804780478, 40'h780404047C, 40'h3844444438,
      40'h00182424FC, 40'h00FC242418, 40'h080404087C, 40'h2454545448,
      40'h04047F0404, 40'h3C4040403C, 40'h1C2040201C, 40'h3C4020403C,
      40'h4428102844, 40'h1C2040A01C, 40'h444C546444, 40'h0041360800,
      40'h00007F0000, 40'h0008364100, 40'h0810080810
   };

endpackage

### design/lcd_glyph_page_renderer_unit.sv
// Top level of the 5x7 text renderer for a page-organised monochrome LCD.
// Depends on lgpr_pkg (font ROM, command codes) and lgpr_ram (frame store).
//
// Usage: the req_ channel carries one character word (column_pos, row_pos, char_code).
// The glyph is OR-merged into a frame store of PAGE_COUNT pages by COLUMN_COUNT columns
// and the rsp_ channel streams the display words: for each glyph column that lies on the
// panel, page select, column high nibble, column low nibble and the merged data byte,
// first for the spill page when the row is not page aligned and that page is on the
// panel, then for the home page. rsp_last_byte marks the final word of a character;
// a character entirely off the panel yields no words at all.
// Sequencing: one character at a time, with req_stall high until it is done. Each
// column starts with a glyph shifting step (S_COL); each cell then has a frame store
// read (S_READ), a merge and write back (S_MERGE) and its four words (S_EMIT).
// After acceptance the sequencer passes S_COL, S_READ and S_MERGE before the first
// word is registered in S_EMIT.
// Reset: the frame store is swept to zero, one entry a cycle, all PAGE_COUNT*COLUMN_COUNT
// entries (1024 by default), with req_stall held high meanwhile.
// Stall: a stalled rsp_ word holds and the sequencer waits; the last word may still be
// waiting while the next character is accepted.
module lcd_glyph_page_renderer_unit
   import lgpr_pkg::*;
#(
   parameter int PAGE_COUNT   = DEF_PAGE_COUNT,
   parameter int COLUMN_COUNT = DEF_COLUMN_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [6:0] req_column_pos,
   input  logic [5:0] req_row_pos,
   input  logic [6:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_lcd_byte,
   output logic       rsp_is_data,
   output logic       rsp_last_byte
);

   localparam int DEPTH = PAGE_COUNT * COLUMN_COUNT;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(GLYPH_COLUMNS);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_COL,
      S_READ,
      S_MERGE,
      S_EMIT
   } state_type;

   state_type       state_ff;
   logic [AW-1:0]   clr_addr_ff;
   logic [7:0]      col_ff;
   logic [2:0]      page_ff;
   logic [2:0]      off_ff;
   logic [KW-1:0]   kidx_ff;
   logic [39:0]     glyph_ff;
   logic [15:0]     shift_ff;
   logic            cell_spill_ff;
   logic [7:0]      merged_ff;
   slot_type        slot_ff;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_lcd_byte_ff;
   logic            rsp_is_data_ff;
   logic            rsp_last_byte_ff;

   logic            accept;
   logic            printable;
   logic [6:0]      glyph_idx;
   logic [3:0]      cell_page;
   logic [AW-1:0]   cell_addr;
   logic [7:0]      cell_bits;
   logic [7:0]      merged;
   logic            last_col;
   logic            spill_ok;
   logic            slot_free;
   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   logic [7:0]      ram_wr_data;
   logic            ram_rd_en;
   logic [7:0]      ram_rd_data;

   // Input handshake and glyph selection.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign printable = (req_char_code >= FIRST_CODE) &&
                      (32'(req_char_code) < 32'(FIRST_CODE) + GLYPH_TOTAL);
   assign glyph_idx = printable ? 7'(req_char_code - FIRST_CODE) : 7'd0;

   // Current cell: spill page below the home page, or the home page itself.
   assign cell_page = cell_spill_ff ? 4'({1'b0, page_ff} + 4'd1) : {1'b0, page_ff};
   assign cell_addr = AW'(32'(cell_page) * COLUMN_COUNT + 32'(col_ff));
   assign cell_bits = cell_spill_ff ? shift_ff[15:8] : shift_ff[7:0];
   assign merged    = ram_rd_data | cell_bits;

   // Column bookkeeping: the on-panel columns of a glyph are always a leading run.
   assign last_col  = (kidx_ff == KW'(GLYPH_COLUMNS - 1)) ||
                      (32'(col_ff) + 1 >= COLUMN_COUNT);
   assign spill_ok  = (off_ff != 3'd0) && (32'(page_ff) + 1 < PAGE_COUNT);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Frame store port control.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cell_addr;
      ram_wr_data = merged;
      ram_rd_en   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = 8'h00;
         end
         S_READ: begin
            ram_rd_en = 1'b1;
         end
         S_MERGE: begin
            ram_wr_en = 1'b1;
         end
         S_IDLE, S_COL, S_EMIT: begin
            ram_wr_en = 1'b0;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   lgpr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cell_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer, shared shift unit and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         cell_spill_ff <= 1'b0;
      end else begin
         // A taken word frees the output register; in S_EMIT the slot is refilled below.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= AW'(clr_addr_ff + 1'b1);
               if (clr_addr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  col_ff   <= {1'b0, req_column_pos};
                  page_ff  <= req_row_pos[5:3];
                  off_ff   <= req_row_pos[2:0];
                  kidx_ff  <= '0;
                  glyph_ff <= printable ? FONT_ROM[glyph_idx] : 40'h0;
                  if (32'(req_row_pos[5:3]) < PAGE_COUNT) begin
                     state_ff <= S_COL;
                  end
               end
            end
            S_COL: begin
               // Columns past the right edge end the character.
               if (32'(col_ff) >= COLUMN_COUNT) begin
                  state_ff <= S_IDLE;
               end else begin
                  shift_ff      <= 16'({8'h00, glyph_ff[7:0]} << off_ff);
                  glyph_ff      <= {8'h00, glyph_ff[39:8]};
                  cell_spill_ff <= spill_ok;
                  state_ff      <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_MERGE;
            end
            S_MERGE: begin
               merged_ff <= merged;
               slot_ff   <= SLOT_PAGE;
               state_ff  <= S_EMIT;
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_is_data_ff   <= 1'b0;
                  rsp_last_byte_ff <= 1'b0;
                  unique case (slot_ff)
                     SLOT_PAGE: begin
                        rsp_lcd_byte_ff <= CMD_PAGE_SELECT | {4'h0, cell_page};
                        slot_ff         <= SLOT_COL_HIGH;
                     end
                     SLOT_COL_HIGH: begin
                        rsp_lcd_byte_ff <= CMD_COL_HIGH | {4'h0, col_ff[7:4]};
                        slot_ff         <= SLOT_COL_LOW;
                     end
                     SLOT_COL_LOW: begin
                        rsp_lcd_byte_ff <= NIBBLE_MASK & col_ff;
                        slot_ff         <= SLOT_DATA;
                     end
                     SLOT_DATA: begin
                        rsp_lcd_byte_ff  <= merged_ff;
                        rsp_is_data_ff   <= 1'b1;
                        rsp_last_byte_ff <= !cell_spill_ff && last_col;
                        if (cell_spill_ff) begin
                           cell_spill_ff <= 1'b0;
                           state_ff      <= S_READ;
                        end else if (last_col) begin
                           state_ff <= S_IDLE;
                        end else begin
                           kidx_ff  <= KW'(kidx_ff + 1'b1);
                           col_ff   <= 8'(col_ff + 8'd1);
                           state_ff <= S_COL;
                        end
                     end
                     default: begin
                        slot_ff <= SLOT_PAGE;
                     end
                  endcase
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lcd_byte  = rsp_lcd_byte_ff;
   assign rsp_is_data   = rsp_is_data_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

`ifndef SYNTHESIS
   // No word may leave while the frame store is being cleared.
   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("output word during frame store clear");

   // The end-of-character flag is only ever set on a data word.
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_byte_ff |-> rsp_is_data_ff)
      else $error("last flag on a command word");

   // Merging only ever adds pixels to a stored cell.
   a_merge_or: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MERGE |-> (ram_wr_data & ram_rd_data) == ram_rd_data)
      else $error("merge cleared pixels in the frame store");

   // A spill cell is only drawn when its page lies on the panel.
   a_spill_page: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ && cell_spill_ff |-> 32'(cell_page) < PAGE_COUNT)
      else $error("spill cell beyond the last page");
`endif

endmodule

### design/lgpr_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies; used for the frame store of the glyph page renderer.
module lgpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read share the clock; the read returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
